@@ hw/rtl/pgeb_pkg.sv @@
`timescale 1ns / 1ps

package pgeb_pkg;

    // Fixed field widths.
    localparam int COORD_W    = 24;
    localparam int SUM_W      = 40;
    localparam int CNT_W      = 16;
    localparam int IDX_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;
    localparam int SIZE_W     = 23;

    // Divider shape: four quotient bits are resolved in each cycle.
    localparam int RADIX_BITS        = 4;
    localparam int FRONT_DIV_CYCLES  = 6;
    localparam int BACK_DIV_CYCLES   = 10;

    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Request operation codes.
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS  = 2'd3;

    // Classified request as it travels from the front to the back.
    typedef struct packed {
        logic                      op;
        logic                      hit;
        logic signed [COORD_W-1:0] z;
        logic [IDX_W-1:0]          ri;
    } pgeb_entry_t;

    // One grid cell in the store.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
    } pgeb_cell_t;

endpackage

@@ hw/rtl/pgeb_queue.sv @@
`timescale 1ns / 1ps

module pgeb_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   fill_reg, fill_next;
    logic         do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage slots carry no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/pgeb_front.sv @@
`timescale 1ns / 1ps

module pgeb_front #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic                                         op,
    input  logic signed [pgeb_pkg::COORD_W-1:0]          point_x,
    input  logic signed [pgeb_pkg::COORD_W-1:0]          point_y,
    input  logic signed [pgeb_pkg::COORD_W-1:0]          point_z,
    input  logic [pgeb_pkg::IDX_W-1:0]                   cell_index,
    input  logic                                         clear_busy,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0]             width_eff,
    input  logic [$clog2(MAX_ROWS+1)-1:0]                height_eff,
    input  logic [pgeb_pkg::SIZE_W-1:0]                  size_eff,
    output logic                                         push_valid,
    input  logic                                         push_ready,
    output pgeb_pkg::pgeb_entry_t                        push_ctl,
    output logic [((MAX_COLUMNS*MAX_ROWS > 1) ?
                   $clog2(MAX_COLUMNS*MAX_ROWS) : 1)-1:0] push_addr
);

    localparam int CELL_TOTAL = MAX_COLUMNS * MAX_ROWS;
    localparam int AW = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int QW = pgeb_pkg::COORD_W;
    localparam int SW = $clog2(pgeb_pkg::FRONT_DIV_CYCLES);

    typedef enum logic [4:0] {
        F_IDLE  = 5'b00001,
        F_DIV   = 5'b00010,
        F_CLAMP = 5'b00100,
        F_ADDR  = 5'b01000,
        F_PUSH  = 5'b10000
    } front_state_t;

    front_state_t          state_reg, state_next;
    pgeb_pkg::pgeb_entry_t ent_reg, ent_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [QW-1:0]         dvx_reg, dvx_next, dvy_reg, dvy_next;
    logic [QW-1:0]         remx_reg, remx_next, remy_reg, remy_next;
    logic                  negx_reg, negx_next, negy_reg, negy_next;
    logic [SW-1:0]         step_reg, step_next;
    logic [CW-1:0]         col_reg, col_next;
    logic [RW-1:0]         row_reg, row_next;
    logic                  accept;
    logic [QW-1:0]         divisor;
    logic [QW-1:0]         sx_dvd, sy_dvd, sx_rem, sy_rem;
    logic [31:0]           flat_idx;

    assign in_ready   = (state_reg == F_IDLE) && !clear_busy;
    assign accept     = in_valid && in_ready;
    assign push_valid = (state_reg == F_PUSH);
    assign push_ctl   = ent_reg;
    assign push_addr  = addr_reg;
    assign divisor    = {1'b0, size_eff};

    // Radix-16 restoring step for both coordinates at once.
    always_comb
    begin
        sx_dvd = dvx_reg;
        sy_dvd = dvy_reg;
        sx_rem = remx_reg;
        sy_rem = remy_reg;
        for (int k = 0; k < pgeb_pkg::RADIX_BITS; k++)
        begin
            sx_rem = {sx_rem[QW-2:0], sx_dvd[QW-1]};
            sx_dvd = {sx_dvd[QW-2:0], 1'b0};
            if (sx_rem >= divisor)
            begin
                sx_rem    = sx_rem - divisor;
                sx_dvd[0] = 1'b1;
            end
            sy_rem = {sy_rem[QW-2:0], sy_dvd[QW-1]};
            sy_dvd = {sy_dvd[QW-2:0], 1'b0};
            if (sy_rem >= divisor)
            begin
                sy_rem    = sy_rem - divisor;
                sy_dvd[0] = 1'b1;
            end
        end
    end

    assign flat_idx = 32'(row_reg) * 32'(width_eff) + 32'(col_reg);

    // Request classification and binning sequence.
    always_comb
    begin
        state_next = state_reg;
        ent_next   = ent_reg;
        addr_next  = addr_reg;
        dvx_next   = dvx_reg;
        dvy_next   = dvy_reg;
        remx_next  = remx_reg;
        remy_next  = remy_reg;
        negx_next  = negx_reg;
        negy_next  = negy_reg;
        step_next  = step_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    ent_next.op = op;
                    ent_next.z  = point_z;
                    ent_next.ri = cell_index;
                    if (op == pgeb_pkg::OP_READ)
                    begin
                        ent_next.hit = (32'(cell_index) < 32'(CELL_TOTAL));
                        addr_next    = AW'(32'(cell_index));
                        state_next   = F_PUSH;
                    end
                    else
                    begin
                        ent_next.hit = 1'b1;
                        dvx_next     = {1'b0, point_x[QW-2:0]};
                        dvy_next     = {1'b0, point_y[QW-2:0]};
                        negx_next    = point_x[QW-1];
                        negy_next    = point_y[QW-1];
                        remx_next    = '0;
                        remy_next    = '0;
                        step_next    = '0;
                        state_next   = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                dvx_next  = sx_dvd;
                dvy_next  = sy_dvd;
                remx_next = sx_rem;
                remy_next = sy_rem;
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(pgeb_pkg::FRONT_DIV_CYCLES - 1))
                begin
                    state_next = F_CLAMP;
                end
            end
            F_CLAMP:
            begin
                // Negative quotients land in the first column or row.
                if (negx_reg)
                begin
                    col_next = '0;
                end
                else if (32'(dvx_reg) >= 32'(width_eff))
                begin
                    col_next = CW'(width_eff - 1'b1);
                end
                else
                begin
                    col_next = CW'(dvx_reg);
                end
                if (negy_reg)
                begin
                    row_next = '0;
                end
                else if (32'(dvy_reg) >= 32'(height_eff))
                begin
                    row_next = RW'(height_eff - 1'b1);
                end
                else
                begin
                    row_next = RW'(dvy_reg);
                end
                state_next = F_ADDR;
            end
            F_ADDR:
            begin
                addr_next  = AW'(flat_idx);
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        addr_reg <= addr_next;
        dvx_reg  <= dvx_next;
        dvy_reg  <= dvy_next;
        remx_reg <= remx_next;
        remy_reg <= remy_next;
        negx_reg <= negx_next;
        negy_reg <= negy_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
    end

`ifndef NO_ASSERTIONS
    // No request is taken while the back end clears the store.
    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !clear_busy)
        else $error("front accepted during clearing pass");

    // An add request always enters the divider next.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == pgeb_pkg::OP_ADD) |=> (state_reg == F_DIV))
        else $error("add request skipped the divider");

    // A pending push holds until the queue takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_ready) |=> (push_valid && $stable(addr_reg)))
        else $error("queue push dropped");
`endif

endmodule

@@ hw/rtl/pgeb_back.sv @@
`timescale 1ns / 1ps

module pgeb_back #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         pop_valid,
    output logic                                         pop_ready,
    input  pgeb_pkg::pgeb_entry_t                        pop_ctl,
    input  logic [((MAX_COLUMNS*MAX_ROWS > 1) ?
                   $clog2(MAX_COLUMNS*MAX_ROWS) : 1)-1:0] pop_addr,
    input  logic [pgeb_pkg::CNT_W-1:0]                   min_points,
    output logic                                         clear_busy,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic signed [pgeb_pkg::COORD_W-1:0]          mean_elevation,
    output logic [pgeb_pkg::CNT_W-1:0]                   point_count,
    output logic [pgeb_pkg::IDX_W-1:0]                   read_index
);

    localparam int CELL_TOTAL = MAX_COLUMNS * MAX_ROWS;
    localparam int AW = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
    localparam int DW = pgeb_pkg::SUM_W;
    localparam int RMW = pgeb_pkg::CNT_W + 1;
    localparam int SW = $clog2(pgeb_pkg::BACK_DIV_CYCLES);
    localparam int MW = pgeb_pkg::COORD_W;

    typedef enum logic [4:0] {
        B_CLEAR = 5'b00001,
        B_IDLE  = 5'b00010,
        B_LOOK  = 5'b00100,
        B_DIV   = 5'b01000,
        B_OUT   = 5'b10000
    } back_state_t;

    pgeb_pkg::pgeb_cell_t  mem [CELL_TOTAL];
    pgeb_pkg::pgeb_cell_t  rd_data_reg;
    back_state_t           state_reg, state_next;
    logic [AW-1:0]         clr_reg, clr_next;
    pgeb_pkg::pgeb_entry_t ent_reg, ent_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [pgeb_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic [DW-1:0]         dvd_reg, dvd_next;
    logic [RMW-1:0]        rem_reg, rem_next;
    logic [SW-1:0]         step_reg, step_next;
    logic signed [MW-1:0]  mean_reg, mean_next;
    logic                  rd_en;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    pgeb_pkg::pgeb_cell_t  wr_data;
    logic [DW-1:0]         s_dvd;
    logic [RMW-1:0]        s_rem, divisor;

    assign clear_busy     = (state_reg == B_CLEAR);
    assign pop_ready      = (state_reg == B_IDLE);
    assign out_valid      = (state_reg == B_OUT);
    assign mean_elevation = mean_reg;
    assign point_count    = cnt_reg;
    assign read_index     = ent_reg.ri;
    assign divisor        = {1'b0, cnt_reg};

    // Radix-16 restoring step of the mean divider.
    always_comb
    begin
        s_dvd = dvd_reg;
        s_rem = rem_reg;
        for (int k = 0; k < pgeb_pkg::RADIX_BITS; k++)
        begin
            s_rem = {s_rem[RMW-2:0], s_dvd[DW-1]};
            s_dvd = {s_dvd[DW-2:0], 1'b0};
            if (s_rem >= divisor)
            begin
                s_rem    = s_rem - divisor;
                s_dvd[0] = 1'b1;
            end
        end
    end

    // Store access sequence: clear, read, update, divide, deliver.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ent_next   = ent_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        mean_next  = mean_reg;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = addr_reg;
        wr_data    = '0;
        unique case (state_reg)
            B_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(CELL_TOTAL - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    ent_next  = pop_ctl;
                    addr_next = pop_addr;
                    if (pop_ctl.hit)
                    begin
                        rd_en      = 1'b1;
                        state_next = B_LOOK;
                    end
                    else
                    begin
                        // Read outside the store: empty result, no update.
                        cnt_next   = '0;
                        mean_next  = '0;
                        state_next = B_OUT;
                    end
                end
            end
            B_LOOK:
            begin
                if (ent_reg.op == pgeb_pkg::OP_ADD)
                begin
                    // A saturated cell drops the point.
                    wr_en         = (rd_data_reg.count != pgeb_pkg::COUNT_MAX);
                    wr_data.sum   = rd_data_reg.sum
                                  + {{(DW - MW){ent_reg.z[MW-1]}}, ent_reg.z};
                    wr_data.count = rd_data_reg.count + 1'b1;
                    state_next    = B_IDLE;
                end
                else
                begin
                    wr_en    = 1'b1;
                    cnt_next = rd_data_reg.count;
                    if (rd_data_reg.count != '0 && rd_data_reg.count >= min_points)
                    begin
                        neg_next   = rd_data_reg.sum[DW-1];
                        dvd_next   = rd_data_reg.sum[DW-1] ? DW'(-rd_data_reg.sum)
                                                           : DW'(rd_data_reg.sum);
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = B_DIV;
                    end
                    else
                    begin
                        mean_next  = '0;
                        state_next = B_OUT;
                    end
                end
            end
            B_DIV:
            begin
                dvd_next  = s_dvd;
                rem_next  = s_rem;
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(pgeb_pkg::BACK_DIV_CYCLES - 1))
                begin
                    // The magnitude of the mean always fits the output field.
                    mean_next  = neg_reg ? -MW'(s_dvd) : MW'(s_dvd);
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        addr_reg <= addr_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        mean_reg <= mean_next;
    end

    // Cell store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[pop_addr];
        end
    end

`ifndef NO_ASSERTIONS
    // A nonzero mean comes only from a cell that met the threshold.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mean_elevation != '0) |->
        (point_count != '0 && point_count >= min_points))
        else $error("mean reported below threshold");

    // An add finishes its update in the look-up state and returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_LOOK && ent_reg.op == pgeb_pkg::OP_ADD) |=>
        (state_reg == B_IDLE))
        else $error("add update did not retire");

    // Out-of-range reads never touch the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready && !pop_ctl.hit) |-> !rd_en)
        else $error("store read for out-of-range index");
`endif

endmodule

@@ hw/rtl/point_grid_elevation_binning.sv @@
`timescale 1ns / 1ps
// Front: a read request goes straight to its push; an add runs the coordinate divider first.
// The front takes one request at a time and accepts the next only after its push is taken.
// Back end: a read looks up its cell and runs the mean divider only when the threshold is met.
// Reset: asynchronous, active low; registers return to 64, 64, 256 and 2.
// After reset a clearing pass zeroes the whole store; no request is taken until it ends.

module point_grid_elevation_binning #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [pgeb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pgeb_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  op,
    input  logic signed [pgeb_pkg::COORD_W-1:0]   point_x,
    input  logic signed [pgeb_pkg::COORD_W-1:0]   point_y,
    input  logic signed [pgeb_pkg::COORD_W-1:0]   point_z,
    input  logic [pgeb_pkg::IDX_W-1:0]            cell_index,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pgeb_pkg::COORD_W-1:0]   mean_elevation,
    output logic [pgeb_pkg::CNT_W-1:0]            point_count,
    output logic [pgeb_pkg::IDX_W-1:0]            read_index
);

    localparam int CELL_TOTAL = MAX_COLUMNS * MAX_ROWS;
    localparam int AW = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
    localparam int WW = $clog2(MAX_COLUMNS + 1);
    localparam int HW = $clog2(MAX_ROWS + 1);
    localparam int EW = $bits(pgeb_pkg::pgeb_entry_t);
    localparam int QW = EW + AW;

    logic [6:0]                     grid_width_reg;
    logic [6:0]                     grid_height_reg;
    logic [pgeb_pkg::SIZE_W-1:0]    cell_size_reg;
    logic [pgeb_pkg::CNT_W-1:0]     min_points_reg;
    logic [WW-1:0]                  width_eff;
    logic [HW-1:0]                  height_eff;
    logic [pgeb_pkg::SIZE_W-1:0]    size_eff;
    logic                           clear_busy;
    logic                           push_valid, push_ready;
    pgeb_pkg::pgeb_entry_t          push_ctl, pop_ctl;
    logic [AW-1:0]                  push_addr, pop_addr;
    logic                           pop_valid, pop_ready;
    logic [QW-1:0]                  pop_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= 7'd64;
            grid_height_reg <= 7'd64;
            cell_size_reg   <= 23'd256;
            min_points_reg  <= 16'd2;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pgeb_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[6:0];
                pgeb_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data[6:0];
                pgeb_pkg::REG_CELL_SIZE:   cell_size_reg   <= cfg_data;
                pgeb_pkg::REG_MIN_POINTS:  min_points_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Effective grid shape and cell size; zero counts as one, a grid size above the maximum is clamped.
    always_comb
    begin
        if (grid_width_reg == 7'd0)
        begin
            width_eff = WW'(1);
        end
        else if (32'(grid_width_reg) > 32'(MAX_COLUMNS))
        begin
            width_eff = WW'(MAX_COLUMNS);
        end
        else
        begin
            width_eff = WW'(grid_width_reg);
        end
        if (grid_height_reg == 7'd0)
        begin
            height_eff = HW'(1);
        end
        else if (32'(grid_height_reg) > 32'(MAX_ROWS))
        begin
            height_eff = HW'(MAX_ROWS);
        end
        else
        begin
            height_eff = HW'(grid_height_reg);
        end
        size_eff = (cell_size_reg == '0) ? pgeb_pkg::SIZE_W'(1) : cell_size_reg;
    end

    pgeb_front #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .cell_index (cell_index),
        .clear_busy (clear_busy),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .size_eff   (size_eff),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_ctl   (push_ctl),
        .push_addr  (push_addr)
    );

    pgeb_queue #(
        .W(QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_ctl, push_addr}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_ctl  = pop_data[QW-1:AW];
    assign pop_addr = pop_data[AW-1:0];

    pgeb_back #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_ctl        (pop_ctl),
        .pop_addr       (pop_addr),
        .min_points     (min_points_reg),
        .clear_busy     (clear_busy),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mean_elevation (mean_elevation),
        .point_count    (point_count),
        .read_index     (read_index)
    );

endmodule
